@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the postfix evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PSEV_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define PSEV_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PSEV_ASSERT(label, clk, rstn, prop)
`define PSEV_NEVER(label, clk, rstn, cond)
`endif

`endif

@@ hw/rtl/psev_pkg.sv @@
// Types, constants and codes shared by the postfix evaluator modules.
package psev_pkg;

    localparam int VALUE_W       = 32;
    localparam int FRACTION_BITS = 16;
    localparam int STACK_DEPTH   = 16;
    localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_DEPTH_W   = 5;
    localparam int OPC_W         = 3;
    localparam int ERR_W         = 3;
    localparam int DIVIDEND_W    = VALUE_W + FRACTION_BITS;
    localparam int DIV_CNT_W     = $clog2(DIVIDEND_W);
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_APPLY = 1'b1;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_ZERO = 3'd4
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_UNDER = 3'd1,
        ERR_OVER  = 3'd2,
        ERR_DIV0  = 3'd3,
        ERR_SAT   = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_ABOVE = 2'd1,
        CELL_TAKE_BELOW = 2'd2
    } cell_op_t;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } stack_op_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [VALUE_W-1:0] quotient;
    } div_res_t;

endpackage

@@ hw/rtl/postfix_stack_evaluator_unit.sv @@
// Postfix expression evaluator over a shifting chain of Q16.16 stack cells.
// An accepted word moves from idle to execute and then to done, where its result word is loaded
// once the output is free; a multiply first takes the registered product in a multiply state, and a
// divide by a non-zero divisor waits in a divide state for the 48 iterations of the radix-2 divider.
// One word is in flight at a time, so a new word is taken only once the unit is idle again.
// Reset (aresetn low, synchronous) empties the stack and clears the output valid.
`include "assert_macros.svh"

module postfix_stack_evaluator_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // number [31:0], operator_code [34:32], zero fill [39:35]
    input  logic [psev_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode [0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // top_value [31:0], stack_depth [36:32], error_code [39:37]
    output logic [psev_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int VW = psev_pkg::VALUE_W;
    localparam int NC = psev_pkg::STACK_DEPTH;
    localparam int DPW = psev_pkg::DEPTH_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [DPW-1:0]                   depth_reg, depth_next;
    psev_pkg::err_t                   err_reg, err_next;
    logic                             mode_reg;
    logic [VW-1:0]                    number_reg;
    logic [psev_pkg::OPC_W-1:0]       opc_reg;
    logic                             m_tvalid_reg;
    logic [psev_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic signed [2*VW-1:0]           prod_reg;

    psev_pkg::stack_op_t              stack_op;
    psev_pkg::cell_op_t               cell_op [NC];
    logic [VW-1:0]                    cell_value [NC];
    logic [VW-1:0]                    wdata;
    logic                             div_start;
    psev_pkg::div_res_t               div_res;

    logic [VW-1:0]                    right_op;
    logic [VW-1:0]                    left_op;
    logic [VW:0]                      sum_wide;
    logic [VW:0]                      dif_wide;
    logic [VW-1:0]                    sum_val;
    logic [VW-1:0]                    dif_val;
    logic                             sum_sat;
    logic                             dif_sat;
    logic signed [2*VW-1:0]           prod_shift;
    logic                             prod_sat;
    logic [VW-1:0]                    prod_val;
    logic [VW-1:0]                    div0_val;
    logic                             accept_in;
    logic                             out_free;
    logic [VW-1:0]                    top_val;

    assign right_op = cell_value[0];
    assign left_op  = cell_value[1];

    assign sum_wide = {left_op[VW-1], left_op} + {right_op[VW-1], right_op};
    assign dif_wide = {left_op[VW-1], left_op} - {right_op[VW-1], right_op};
    assign sum_sat  = sum_wide[VW] ^ sum_wide[VW-1];
    assign dif_sat  = dif_wide[VW] ^ dif_wide[VW-1];
    assign sum_val  = sum_sat ? (sum_wide[VW] ? psev_pkg::VAL_MIN : psev_pkg::VAL_MAX)
                              : sum_wide[VW-1:0];
    assign dif_val  = dif_sat ? (dif_wide[VW] ? psev_pkg::VAL_MIN : psev_pkg::VAL_MAX)
                              : dif_wide[VW-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= (2*VW)'($signed(left_op)) * (2*VW)'($signed(right_op));
    end

    assign prod_shift = prod_reg >>> psev_pkg::FRACTION_BITS;
    assign prod_sat   = !((&prod_shift[2*VW-1:VW-1]) || !(|prod_shift[2*VW-1:VW-1]));
    assign prod_val   = prod_sat ? (prod_shift[2*VW-1] ? psev_pkg::VAL_MIN : psev_pkg::VAL_MAX)
                                 : prod_shift[VW-1:0];

    assign div0_val = left_op[VW-1] ? psev_pkg::VAL_MIN
                    : ((|left_op) ? psev_pkg::VAL_MAX : '0);

    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        stack_op   = psev_pkg::STK_HOLD;
        wdata      = number_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                err_next   = psev_pkg::ERR_OK;
                if (mode_reg == psev_pkg::MODE_PUSH) begin
                    if (depth_reg == DPW'(NC)) begin
                        err_next = psev_pkg::ERR_OVER;
                    end else begin
                        stack_op   = psev_pkg::STK_PUSH;
                        depth_next = depth_reg + DPW'(1);
                    end
                end else if (depth_reg < DPW'(2)) begin
                    err_next = psev_pkg::ERR_UNDER;
                end else begin
                    case (psev_pkg::opcode_t'(opc_reg))
                        psev_pkg::OP_ADD: begin
                            stack_op   = psev_pkg::STK_POP;
                            depth_next = depth_reg - DPW'(1);
                            wdata      = sum_val;
                            if (sum_sat) begin
                                err_next = psev_pkg::ERR_SAT;
                            end
                        end
                        psev_pkg::OP_SUB: begin
                            stack_op   = psev_pkg::STK_POP;
                            depth_next = depth_reg - DPW'(1);
                            wdata      = dif_val;
                            if (dif_sat) begin
                                err_next = psev_pkg::ERR_SAT;
                            end
                        end
                        psev_pkg::OP_MUL: begin
                            state_next = ST_MUL;
                        end
                        psev_pkg::OP_DIV: begin
                            if (right_op == '0) begin
                                stack_op   = psev_pkg::STK_POP;
                                depth_next = depth_reg - DPW'(1);
                                wdata      = div0_val;
                                err_next   = psev_pkg::ERR_DIV0;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: begin
                            stack_op   = psev_pkg::STK_POP;
                            depth_next = depth_reg - DPW'(1);
                            wdata      = '0;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                stack_op   = psev_pkg::STK_POP;
                depth_next = depth_reg - DPW'(1);
                wdata      = prod_val;
                if (prod_sat) begin
                    err_next = psev_pkg::ERR_SAT;
                end
                state_next = ST_DONE;
            end
            ST_DIV: begin
                wdata = div_res.quotient;
                if (div_res.done) begin
                    stack_op   = psev_pkg::STK_POP;
                    depth_next = depth_reg - DPW'(1);
                    if (div_res.sat) begin
                        err_next = psev_pkg::ERR_SAT;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            err_reg      <= psev_pkg::ERR_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            mode_reg   <= s_tuser;
            number_reg <= s_tdata[VW-1:0];
            opc_reg    <= s_tdata[VW+psev_pkg::OPC_W-1:VW];
        end
        if (state_reg == ST_DONE && out_free) begin
            m_tdata_reg <= {err_reg, psev_pkg::OUT_DEPTH_W'(depth_reg), top_val};
        end
    end

    assign top_val = (depth_reg != '0) ? cell_value[0] : '0;

    for (genvar i = 0; i < NC; i++) begin : g_cell
        logic [VW-1:0] above;
        logic [VW-1:0] below;

        if (i == 0) begin : g_head
            assign above = wdata;
        end else begin : g_body
            assign above = cell_value[i-1];
        end

        if (i == NC - 1) begin : g_tail
            assign below = cell_value[i];
        end else begin : g_inner
            assign below = cell_value[i+1];
        end

        always_comb begin
            case (stack_op)
                psev_pkg::STK_PUSH: cell_op[i] = psev_pkg::CELL_TAKE_ABOVE;
                psev_pkg::STK_POP:  cell_op[i] = (i == 0) ? psev_pkg::CELL_TAKE_ABOVE
                                                          : psev_pkg::CELL_TAKE_BELOW;
                default:            cell_op[i] = psev_pkg::CELL_HOLD;
            endcase
        end

        psev_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op[i]),
            .from_above (above),
            .from_below (below),
            .value      (cell_value[i])
        );
    end

    psev_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .left    (left_op),
        .right   (right_op),
        .res     (div_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PSEV_NEVER(a_depth_bound, aclk, aresetn, depth_reg > DPW'(NC))
    `PSEV_ASSERT(a_accept_to_exec, aclk, aresetn, accept_in |=> (state_reg == ST_EXEC))
    `PSEV_ASSERT(a_underflow_keeps_depth, aclk, aresetn,
        (state_reg == ST_EXEC && mode_reg == psev_pkg::MODE_APPLY && depth_reg < DPW'(2))
        |=> $stable(depth_reg))
    `PSEV_ASSERT(a_done_loads_output, aclk, aresetn,
        (state_reg == ST_DONE && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))

endmodule

@@ hw/rtl/psev_cell.sv @@
// One stack cell: holds one entry and takes its neighbor's entry on a shift.
module psev_cell (
    input  logic                           aclk,
    input  psev_pkg::cell_op_t             op,
    input  logic [psev_pkg::VALUE_W-1:0]   from_above,
    input  logic [psev_pkg::VALUE_W-1:0]   from_below,
    output logic [psev_pkg::VALUE_W-1:0]   value
);

    logic [psev_pkg::VALUE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        case (op)
            psev_pkg::CELL_TAKE_ABOVE: value_reg <= from_above;
            psev_pkg::CELL_TAKE_BELOW: value_reg <= from_below;
            default:                   value_reg <= value_reg;
        endcase
    end

    assign value = value_reg;

endmodule

@@ hw/rtl/psev_div.sv @@
// Radix-2 restoring divider for the Q16.16 quotient, one quotient bit per cycle.
`include "assert_macros.svh"

module psev_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [psev_pkg::VALUE_W-1:0]   left,
    input  logic [psev_pkg::VALUE_W-1:0]   right,
    output psev_pkg::div_res_t             res
);

    localparam int VW = psev_pkg::VALUE_W;
    localparam int DW = psev_pkg::DIVIDEND_W;
    localparam int CW = psev_pkg::DIV_CNT_W;
    localparam logic [CW-1:0] LAST_COUNT = CW'(DW - 1);

    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] dq_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;

    logic [VW-1:0] abs_left;
    logic [VW-1:0] abs_right;
    logic [VW:0]   rem_shift;
    logic [VW:0]   diff;
    logic          fits;
    logic          last_step;
    logic          high_set;
    logic          pos_over;
    logic          neg_over;

    assign abs_left  = left[VW-1]  ? (~left + 1'b1)  : left;
    assign abs_right = right[VW-1] ? (~right + 1'b1) : right;
    assign rem_shift = {rem_reg, dq_reg[DW-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};
    assign fits      = !diff[VW];
    assign last_step = busy_reg && (count_reg == LAST_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= last_step;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end else if (busy_reg) begin
                busy_reg  <= !last_step;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= {abs_left, {psev_pkg::FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            dsr_reg <= abs_right;
            neg_reg <= left[VW-1] ^ right[VW-1];
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : rem_shift[VW-1:0];
        end
    end

    // The magnitude may reach 2^31 only when the quotient is negative.
    assign high_set = |dq_reg[DW-1:VW];
    assign pos_over = high_set | dq_reg[VW-1];
    assign neg_over = high_set | (dq_reg[VW-1] & (|dq_reg[VW-2:0]));

    always_comb begin
        res.done = done_reg;
        if (neg_reg) begin
            res.sat      = neg_over;
            res.quotient = neg_over ? psev_pkg::VAL_MIN : (~dq_reg[VW-1:0] + 1'b1);
        end else begin
            res.sat      = pos_over;
            res.quotient = pos_over ? psev_pkg::VAL_MAX : dq_reg[VW-1:0];
        end
    end

    `PSEV_NEVER(a_start_while_busy, aclk, aresetn, start && busy_reg)
    `PSEV_ASSERT(a_done_after_last, aclk, aresetn, last_step |=> (done_reg && !busy_reg))

endmodule

@@ tb/sv/postfix_stack_evaluator_unit_tb.sv @@
// Self-checking testbench for the postfix stack evaluator: directed tokens, then random expressions.
module postfix_stack_evaluator_unit_tb;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;
    localparam logic [31:0] Q_HALF = 32'h0000_8000;

    typedef struct {
        logic [31:0] top;
        logic [4:0]  depth;
        logic [2:0]  err;
    } token_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [psev_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [psev_pkg::OUT_TDATA_W-1:0] m_tdata;

    logic signed [31:0] shadow_stack [psev_pkg::STACK_DEPTH];
    int shadow_depth = 0;
    token_result_t awaited_results[$];
    bit failed = 1'b0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_stall_left = 0;
    int push_bias = 50;

    postfix_stack_evaluator_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] saturate(input longint v, inout logic [2:0] err);
        if (v > Q_MAX) begin
            err = psev_pkg::ERR_SAT;
            return Q_MAX[31:0];
        end
        if (v < Q_MIN) begin
            err = psev_pkg::ERR_SAT;
            return Q_MIN[31:0];
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] combine_operands(input logic signed [31:0] left,
                                                     input logic signed [31:0] right,
                                                     input logic [2:0] code,
                                                     inout logic [2:0] err);
        longint a;
        longint b;
        longint product;
        a = left;
        b = right;
        case (code)
            psev_pkg::OP_ADD: return saturate(a + b, err);
            psev_pkg::OP_SUB: return saturate(a - b, err);
            psev_pkg::OP_MUL: begin
                product = a * b;
                return saturate(product >>> psev_pkg::FRACTION_BITS, err);
            end
            psev_pkg::OP_DIV: begin
                if (b == 0) begin
                    err = psev_pkg::ERR_DIV0;
                    if (a > 0) return Q_MAX[31:0];
                    if (a < 0) return Q_MIN[31:0];
                    return 32'd0;
                end
                return saturate((a <<< psev_pkg::FRACTION_BITS) / b, err);
            end
            default: return 32'd0;
        endcase
    endfunction

    function automatic token_result_t evaluate_token(input logic mode, input logic [31:0] num,
                                                     input logic [2:0] code);
        token_result_t res;
        logic [2:0] err;
        logic [31:0] value;
        err = psev_pkg::ERR_OK;
        if (mode == psev_pkg::MODE_PUSH) begin
            if (shadow_depth >= psev_pkg::STACK_DEPTH) begin
                err = psev_pkg::ERR_OVER;
            end else begin
                shadow_stack[shadow_depth] = num;
                shadow_depth++;
            end
        end else begin
            if (shadow_depth < 2) begin
                err = psev_pkg::ERR_UNDER;
            end else begin
                value = combine_operands(shadow_stack[shadow_depth-2],
                                         shadow_stack[shadow_depth-1], code, err);
                shadow_depth -= 2;
                shadow_stack[shadow_depth] = value;
                shadow_depth++;
            end
        end
        res.top = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : 32'd0;
        res.depth = shadow_depth[4:0];
        res.err = err;
        return res;
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            4: return 32'd0;
            5: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX[31:0];
                    1: return Q_MIN[31:0];
                    2: return 32'hFFFF_FFFF;
                    3: return 32'd1;
                    default: return Q_ONE;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(input logic mode, input logic [31:0] num, input logic [2:0] code);
        int pause;
        pause = tx_steady ? 0 : pick_pause();
        if (pause > 0) begin
            s_tvalid <= 1'b0;
            repeat (pause) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {5'd0, code, num};
        do @(posedge aclk); while (!s_tready);
        awaited_results.push_back(evaluate_token(mode, num, code));
    endtask

    task automatic push_number(input logic [31:0] num);
        send_token(psev_pkg::MODE_PUSH, num, 3'($urandom_range(0, 7)));
    endtask

    task automatic apply_op(input logic [2:0] code);
        send_token(psev_pkg::MODE_APPLY, $urandom, code);
    endtask

    task automatic test_underflow();
        apply_op(psev_pkg::OP_ADD);
        push_number(Q_ONE);
        apply_op(psev_pkg::OP_MUL);
    endtask

    task automatic test_saturation();
        push_number(Q_MAX[31:0]);
        apply_op(psev_pkg::OP_ADD);
        push_number(Q_MIN[31:0]);
        apply_op(psev_pkg::OP_SUB);
        push_number(Q_MAX[31:0]);
        apply_op(psev_pkg::OP_MUL);
        push_number(32'h0000_0080);
        apply_op(psev_pkg::OP_DIV);
    endtask

    task automatic test_divide_by_zero();
        push_number(32'd0);
        apply_op(psev_pkg::OP_DIV);
        push_number(Q_MIN[31:0]);
        push_number(32'd0);
        apply_op(psev_pkg::OP_DIV);
        push_number(32'd0);
        push_number(32'd0);
        apply_op(psev_pkg::OP_DIV);
    endtask

    task automatic test_product_rounding();
        push_number(32'hFFFF_FFFF);
        push_number(Q_HALF);
        apply_op(psev_pkg::OP_MUL);
    endtask

    task automatic test_unknown_operators();
        push_number(32'h5555_AAAA);
        apply_op(psev_pkg::OP_ZERO);
        apply_op(3'($urandom_range(5, 7)));
    endtask

    task automatic test_stack_overflow();
        tx_steady = 1'b0;
        while (shadow_depth < psev_pkg::STACK_DEPTH) push_number(pick_value());
        push_number(pick_value());
        push_number(pick_value());
        while (shadow_depth > 2) apply_op(3'($urandom_range(0, 3)));
    endtask

    task automatic test_random_expressions(input int count);
        int r;
        logic mode;
        logic [2:0] code;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                tx_steady = ($urandom_range(0, 4) == 0);
                rx_steady = ($urandom_range(0, 4) == 0);
                push_bias = $urandom_range(30, 70);
            end
            r = $urandom_range(0, 99);
            if (shadow_depth < 2) begin
                mode = (r < 90) ? psev_pkg::MODE_PUSH : psev_pkg::MODE_APPLY;
            end else if (shadow_depth >= psev_pkg::STACK_DEPTH) begin
                mode = (r < 85) ? psev_pkg::MODE_APPLY : psev_pkg::MODE_PUSH;
            end else begin
                mode = (r < push_bias) ? psev_pkg::MODE_PUSH : psev_pkg::MODE_APPLY;
            end
            if (mode == psev_pkg::MODE_PUSH) begin
                push_number(pick_value());
            end else begin
                code = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 3))
                                                    : 3'($urandom_range(4, 7));
                apply_op(code);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall_left = 0;
        end else if (rx_stall_left > 0 && !rx_steady) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_tready <= 1'b1;
            rx_stall_left = 0;
            if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall_left = pick_pause();
        end
    end

    always @(posedge aclk) begin : check_results
        token_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result word with no token outstanding: %h", m_tdata);
                failed = 1'b1;
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata[31:0] !== want.top) begin
                    $error("top_value expected %h, actual %h", want.top, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[36:32] !== want.depth) begin
                    $error("stack_depth expected %0d, actual %0d", want.depth, m_tdata[36:32]);
                    failed = 1'b1;
                end
                if (m_tdata[39:37] !== want.err) begin
                    $error("error_code expected %0d, actual %0d", want.err, m_tdata[39:37]);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_underflow();
        test_saturation();
        test_divide_by_zero();
        test_product_rounding();
        test_unknown_operators();
        test_stack_overflow();
        test_random_expressions(400);
        s_tvalid <= 1'b0;
        rx_steady = 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (!failed && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/psev_pkg.sv
hw/rtl/psev_cell.sv
hw/rtl/psev_div.sv
hw/rtl/postfix_stack_evaluator_unit.sv
tb/sv/postfix_stack_evaluator_unit_tb.sv
